// ----- rtl/core/fce_pkg.sv -----
// fce_pkg: shared types, codes and constants of the FAT chain engine.
// No dependencies; used by every module under rtl/core except the generic fce_link_ram.
`timescale 1ns / 1ps

package fce_pkg;

  // Table geometry
  localparam int NUM_BLOCKS      = 1024;
  localparam int BLOCK_BYTES     = 1024;   // power of two
  localparam int RESERVED_BLOCKS = 6;

  // Field widths of the command and response items
  localparam int FUNC_W   = 3;
  localparam int BLOCK_W  = 10;
  localparam int OFFSET_W = 20;
  localparam int STATUS_W = 2;

  // Derived widths and the link entry width
  localparam int ADDR_W       = $clog2(NUM_BLOCKS);
  localparam int LINK_W       = 16;
  localparam int OFFSET_SHIFT = $clog2(BLOCK_BYTES);
  localparam int STEP_W       = OFFSET_W - OFFSET_SHIFT;

  // Link entry encoding
  localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
  localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEEK     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXTEND   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FREE     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TRUNCATE = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BROKEN  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [BLOCK_W-1:0]  start_block;
    logic [OFFSET_W-1:0] byte_offset;
  } cmd_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  block;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // Link table write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  // Entry points to another block of the table
  function automatic logic is_link(input logic [LINK_W-1:0] e);
    return (e != LINK_FREE) && (e != LINK_END) && (32'(e) < NUM_BLOCKS);
  endfunction

endpackage

// ----- rtl/core/fce_link_ram.sv -----
// fce_link_ram: generic simple dual-port RAM, one write and one registered read.
// A read of the address written in the same cycle returns the new data.
`timescale 1ns / 1ps

module fce_link_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with write-first bypass
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/fce_sequencer.sv -----
// fce_sequencer: command state machine that walks, scans and rewrites the link table.
// Depends on fce_pkg; drives the ports of fce_link_ram.
`timescale 1ns / 1ps

module fce_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  fce_pkg::cmd_t               cmd,
  input  logic                        slot_free,
  output logic                        res_load,
  output fce_pkg::rsp_t               res,
  output fce_pkg::link_wr_t           mem_wr,
  output logic [fce_pkg::ADDR_W-1:0]  mem_raddr,
  input  logic [fce_pkg::LINK_W-1:0]  mem_rdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FREE,
    S_SCAN,
    S_LINK,
    S_DONE
  } state_t;

  localparam logic [fce_pkg::ADDR_W-1:0] FIRST_ALLOC =
    fce_pkg::ADDR_W'(fce_pkg::RESERVED_BLOCKS);
  localparam logic [fce_pkg::ADDR_W-1:0] LAST_BLOCK =
    fce_pkg::ADDR_W'(fce_pkg::NUM_BLOCKS - 1);

  state_t                       state, state_next;
  logic [fce_pkg::FUNC_W-1:0]   op, op_next;
  logic [fce_pkg::ADDR_W-1:0]   cur, cur_next;
  logic [fce_pkg::ADDR_W-1:0]   keep_blk, keep_blk_next;
  logic [fce_pkg::ADDR_W-1:0]   scan_idx, scan_idx_next;
  logic [fce_pkg::ADDR_W-1:0]   clr_idx, clr_idx_next;
  logic [fce_pkg::STEP_W-1:0]   cnt, cnt_next;
  logic [fce_pkg::STEP_W-1:0]   steps, steps_next;
  fce_pkg::rsp_t                res_q, res_next;
  logic [fce_pkg::LINK_W-1:0]   e;
  logic                         start_ok;

  assign e         = mem_rdata;
  assign start_ok  = 32'(cmd.start_block) < fce_pkg::NUM_BLOCKS;
  assign cmd_ready = (state == S_IDLE);
  assign res       = res_q;

  // Next-state and memory port logic
  always_comb begin
    state_next    = state;
    op_next       = op;
    cur_next      = cur;
    keep_blk_next = keep_blk;
    scan_idx_next = scan_idx;
    clr_idx_next  = clr_idx;
    cnt_next      = cnt;
    steps_next    = steps;
    res_next      = res_q;
    mem_wr        = '0;
    mem_raddr     = cur;
    res_load      = 1'b0;

    case (state)
      // Post-reset sweep: reserved blocks end a chain, the rest are free
      S_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = clr_idx;
        mem_wr.data = (32'(clr_idx) < fce_pkg::RESERVED_BLOCKS) ?
                      fce_pkg::LINK_END : fce_pkg::LINK_FREE;
        if (clr_idx == LAST_BLOCK) begin
          state_next = S_IDLE;
        end else begin
          clr_idx_next = clr_idx + 1'b1;
        end
      end

      // Take a command and issue its first read
      S_IDLE: begin
        if (cmd_valid) begin
          op_next    = cmd.func;
          cur_next   = fce_pkg::ADDR_W'(cmd.start_block);
          cnt_next   = '0;
          steps_next = fce_pkg::STEP_W'(cmd.byte_offset >> fce_pkg::OFFSET_SHIFT);
          mem_raddr  = fce_pkg::ADDR_W'(cmd.start_block);
          case (cmd.func)
            fce_pkg::FUNC_ALLOC: begin
              mem_raddr     = FIRST_ALLOC;
              scan_idx_next = FIRST_ALLOC;
              state_next    = S_SCAN;
            end
            fce_pkg::FUNC_SEEK, fce_pkg::FUNC_EXTEND, fce_pkg::FUNC_TRUNCATE: begin
              if (cmd.func == fce_pkg::FUNC_EXTEND) begin
                steps_next = '0;
              end
              if (start_ok) begin
                state_next = S_WALK;
              end else begin
                res_next   = '{block: '0, status: fce_pkg::STATUS_BROKEN};
                state_next = S_DONE;
              end
            end
            fce_pkg::FUNC_FREE: begin
              if (start_ok) begin
                state_next = S_FREE;
              end else begin
                res_next   = '{block: '0, status: fce_pkg::STATUS_BROKEN};
                state_next = S_DONE;
              end
            end
            default: begin
              res_next   = '{block: '0, status: fce_pkg::STATUS_OK};
              state_next = S_DONE;
            end
          endcase
        end
      end

      // Follow links; e is the entry of block cur
      S_WALK: begin
        if (e == fce_pkg::LINK_FREE) begin
          res_next   = '{block: '0, status: fce_pkg::STATUS_BROKEN};
          state_next = S_DONE;
        end else if (cnt == steps) begin
          case (op)
            fce_pkg::FUNC_SEEK: begin
              res_next   = '{block: fce_pkg::BLOCK_W'(cur), status: fce_pkg::STATUS_OK};
              state_next = S_DONE;
            end
            fce_pkg::FUNC_EXTEND: begin
              if (e == fce_pkg::LINK_END) begin
                mem_raddr     = FIRST_ALLOC;
                scan_idx_next = FIRST_ALLOC;
                state_next    = S_SCAN;
              end else if (fce_pkg::is_link(e)) begin
                res_next   = '{block: fce_pkg::BLOCK_W'(e), status: fce_pkg::STATUS_OK};
                state_next = S_DONE;
              end else begin
                res_next   = '{block: '0, status: fce_pkg::STATUS_BROKEN};
                state_next = S_DONE;
              end
            end
            default: begin
              // Truncate: reached block becomes the new end, the tail is freed
              mem_wr.en   = 1'b1;
              mem_wr.addr = cur;
              mem_wr.data = fce_pkg::LINK_END;
              if (e == fce_pkg::LINK_END) begin
                res_next   = '{block: fce_pkg::BLOCK_W'(cur), status: fce_pkg::STATUS_OK};
                state_next = S_DONE;
              end else if (fce_pkg::is_link(e)) begin
                keep_blk_next = cur;
                cur_next      = fce_pkg::ADDR_W'(e);
                mem_raddr     = fce_pkg::ADDR_W'(e);
                state_next    = S_FREE;
              end else begin
                res_next   = '{block: '0, status: fce_pkg::STATUS_BROKEN};
                state_next = S_DONE;
              end
            end
          endcase
        end else if (!fce_pkg::is_link(e)) begin
          res_next   = '{block: '0, status: fce_pkg::STATUS_BROKEN};
          state_next = S_DONE;
        end else begin
          cur_next  = fce_pkg::ADDR_W'(e);
          cnt_next  = fce_pkg::STEP_W'(cnt + 1'b1);
          mem_raddr = fce_pkg::ADDR_W'(e);
        end
      end

      // Free the chain block by block; next read overlaps the write
      S_FREE: begin
        if (e == fce_pkg::LINK_FREE) begin
          res_next   = '{block: '0, status: fce_pkg::STATUS_BROKEN};
          state_next = S_DONE;
        end else begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = cur;
          mem_wr.data = fce_pkg::LINK_FREE;
          if (e == fce_pkg::LINK_END) begin
            res_next.status = fce_pkg::STATUS_OK;
            res_next.block  = (op == fce_pkg::FUNC_TRUNCATE) ?
                              fce_pkg::BLOCK_W'(keep_blk) : '0;
            state_next      = S_DONE;
          end else if (!fce_pkg::is_link(e)) begin
            res_next   = '{block: '0, status: fce_pkg::STATUS_BROKEN};
            state_next = S_DONE;
          end else begin
            cur_next  = fce_pkg::ADDR_W'(e);
            mem_raddr = fce_pkg::ADDR_W'(e);
          end
        end
      end

      // Search for the first free block above the reserved area
      S_SCAN: begin
        if (e == fce_pkg::LINK_FREE) begin
          mem_wr.en = 1'b1;
          if (op == fce_pkg::FUNC_ALLOC) begin
            mem_wr.addr = scan_idx;
            mem_wr.data = fce_pkg::LINK_END;
            res_next    = '{block: fce_pkg::BLOCK_W'(scan_idx), status: fce_pkg::STATUS_OK};
            state_next  = S_DONE;
          end else begin
            mem_wr.addr   = cur;
            mem_wr.data   = fce_pkg::LINK_W'(scan_idx);
            keep_blk_next = scan_idx;
            state_next    = S_LINK;
          end
        end else if (scan_idx == LAST_BLOCK) begin
          res_next   = '{block: '0, status: fce_pkg::STATUS_NO_FREE};
          state_next = S_DONE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
          mem_raddr     = scan_idx + 1'b1;
        end
      end

      // Extend: mark the new tail block as chain end
      S_LINK: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = keep_blk;
        mem_wr.data = fce_pkg::LINK_END;
        res_next    = '{block: fce_pkg::BLOCK_W'(keep_blk), status: fce_pkg::STATUS_OK};
        state_next  = S_DONE;
      end

      // Hand the result to the output register when it has room
      S_DONE: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
    op       <= op_next;
    cur      <= cur_next;
    keep_blk <= keep_blk_next;
    scan_idx <= scan_idx_next;
    cnt      <= cnt_next;
    steps    <= steps_next;
    res_q    <= res_next;
  end

endmodule

// ----- rtl/core/fat_chain_engine.sv -----
// fat_chain_engine: top level of the FAT chain engine with the response register.
// Depends on fce_pkg, fce_link_ram and fce_sequencer.
`timescale 1ns / 1ps

// The engine keeps a 1024-entry link table in one RAM and runs one command at a
// time. After reset it writes the table's initial contents, one entry per
// cycle, and holds cmd_ready low during that pass. A command then reads one
// table entry per cycle through the single RAM read port: allocate scans the
// entries from block RESERVED_BLOCKS up to the first free one, seek visits
// byte_offset / BLOCK_BYTES + 1 blocks, truncate the same plus each block freed
// after the cut point, free each block of the chain, and extend only the start
// block, plus a scan and a second write when it allocates. The response sits in
// an output register, so the next command is taken while a finished response
// still waits.

module fat_chain_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  fce_pkg::cmd_t  cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fce_pkg::rsp_t  rsp
);

  fce_pkg::link_wr_t            mem_wr;
  logic [fce_pkg::ADDR_W-1:0]   mem_raddr;
  logic [fce_pkg::LINK_W-1:0]   mem_rdata;
  logic                         slot_free;
  logic                         res_load;
  fce_pkg::rsp_t                res;

  assign slot_free = !rsp_valid || rsp_ready;

  fce_link_ram #(
    .ADDR_W (fce_pkg::ADDR_W),
    .DATA_W (fce_pkg::LINK_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fce_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res       (res),
    .mem_wr    (mem_wr),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (res_load) begin
      rsp <= res;
    end
  end

  // A failed command never reports a block
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != fce_pkg::STATUS_OK) |-> rsp.block == '0)
    else $error("error response carries a nonzero block");

  // Only known status codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == fce_pkg::STATUS_OK) ||
                  (rsp.status == fce_pkg::STATUS_NO_FREE) ||
                  (rsp.status == fce_pkg::STATUS_BROKEN))
    else $error("unknown status code");

  // One command at a time: no transfer in the cycle after a transfer
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while another is in progress");

  // A pending response is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    res_load |-> slot_free)
    else $error("response register overwritten");

endmodule
